[hdl/positional_insert_delete_list_core_defines.svh]
// assertion macros shared by the checker of the list core
`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_DEFINES_SVH

// condition that must hold at every edge out of reset
`define PIDL_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pidl_pkg.sv]
`timescale 1ns / 1ps

package pidl_pkg;

  // default list capacity
  localparam int DEPTH_DEFAULT = 64;

  // command codes
  localparam logic [1:0] CMD_DELETE = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_BADPOS = 2'd3;

  // input transaction
  typedef struct packed {
    logic [1:0]          cmd;
    logic [6:0]          position;
    logic signed [31:0]  new_value;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]          status;
    logic [6:0]          element_count;
    logic signed [31:0]  read_value;
  } out_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUTVAL,
    S_RDATA,
    S_DONE
  } state_t;

endpackage

[hdl/pidl_ram.sv]
`timescale 1ns / 1ps

module pidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/pidl_ctrl.sv]
`timescale 1ns / 1ps

module pidl_ctrl #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  pidl_pkg::in_t            in_data,
  output logic                     ram_rd_en,
  output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
  input  logic [31:0]              ram_rdata,
  output logic                     ram_wr_en,
  output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
  output logic [31:0]              ram_wr_data,
  output logic                     res_valid,
  output pidl_pkg::out_t           res,
  input  logic                     res_take
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

  pidl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [AW-1:0]    pos_addr_r, pos_addr_nxt;
  logic             vld_r, vld_nxt;
  logic             op_ins_r, op_ins_nxt;
  logic [31:0]      val_r, val_nxt;
  pidl_pkg::out_t   res_r, res_nxt;

  logic [CMPW-1:0]  pos_w, cnt_w;
  logic             pos_zero, in_range, ins_range, is_empty, is_full;
  logic             is_del, is_ins, is_rd;
  logic             del_go, ins_go, rd_go;
  logic [1:0]       status_dec;

  // decode of the incoming transaction against the current count
  assign pos_w     = CMPW'(in_data.position);
  assign cnt_w     = CMPW'(count_r);
  assign pos_zero  = (in_data.position == '0);
  assign in_range  = !pos_zero && (pos_w <= cnt_w);
  assign ins_range = !pos_zero && (pos_w <= cnt_w + CMPW'(1));
  assign is_empty  = (count_r == '0);
  assign is_full   = (cnt_w >= CMPW'(DEPTH));
  assign is_del    = (in_data.cmd == pidl_pkg::CMD_DELETE);
  assign is_ins    = (in_data.cmd == pidl_pkg::CMD_INSERT);
  assign is_rd     = (in_data.cmd == pidl_pkg::CMD_READ);
  assign del_go    = is_del && !is_empty && in_range;
  assign ins_go    = is_ins && !is_full && ins_range;
  assign rd_go     = is_rd && in_range;

  // status, emptiness and fullness checked before position
  always_comb begin
    priority if (is_del && is_empty) begin
      status_dec = pidl_pkg::STAT_EMPTY;
    end else if (is_ins && is_full) begin
      status_dec = pidl_pkg::STAT_FULL;
    end else if (del_go || ins_go || rd_go) begin
      status_dec = pidl_pkg::STAT_OK;
    end else begin
      status_dec = pidl_pkg::STAT_BADPOS;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        if (in_valid) begin
          if (del_go || ins_go) begin
            state_nxt = pidl_pkg::S_SHIFT;
          end else if (rd_go) begin
            state_nxt = pidl_pkg::S_RDATA;
          end else begin
            state_nxt = pidl_pkg::S_DONE;
          end
        end
      end
      pidl_pkg::S_SHIFT: begin
        if (left_r == '0) begin
          state_nxt = op_ins_r ? pidl_pkg::S_PUTVAL : pidl_pkg::S_DONE;
        end
      end
      pidl_pkg::S_PUTVAL: state_nxt = pidl_pkg::S_DONE;
      pidl_pkg::S_RDATA:  state_nxt = pidl_pkg::S_DONE;
      pidl_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = pidl_pkg::S_IDLE;
        end
      end
      default: state_nxt = pidl_pkg::S_IDLE;
    endcase
  end

  // memory accesses and datapath updates
  always_comb begin
    count_nxt    = count_r;
    left_nxt     = left_r;
    rd_addr_nxt  = rd_addr_r;
    wa_nxt       = wa_r;
    pos_addr_nxt = pos_addr_r;
    vld_nxt      = 1'b0;
    op_ins_nxt   = op_ins_r;
    val_nxt      = val_r;
    res_nxt      = res_r;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = rd_addr_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = wa_r;
    ram_wr_data  = ram_rdata;
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        if (in_valid) begin
          if (del_go) begin
            count_nxt = count_r - CW'(1);
          end else if (ins_go) begin
            count_nxt = count_r + CW'(1);
          end
          res_nxt.status        = status_dec;
          res_nxt.element_count = 7'(count_nxt);
          res_nxt.read_value    = '0;
          op_ins_nxt   = is_ins;
          val_nxt      = in_data.new_value;
          pos_addr_nxt = AW'(pos_w - CMPW'(1));
          // delete walks upward from the position, insert downward from the top
          if (del_go) begin
            left_nxt    = CW'(cnt_w - pos_w);
            rd_addr_nxt = AW'(pos_w);
          end else if (ins_go) begin
            left_nxt    = CW'(cnt_w + CMPW'(1) - pos_w);
            rd_addr_nxt = AW'(cnt_w - CMPW'(1));
          end else begin
            left_nxt    = '0;
          end
          if (rd_go) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(pos_w - CMPW'(1));
          end
        end
      end
      pidl_pkg::S_SHIFT: begin
        // write back the entry read last cycle one place over
        ram_wr_en = vld_r;
        if (left_r != '0) begin
          ram_rd_en = 1'b1;
          left_nxt  = left_r - CW'(1);
          vld_nxt   = 1'b1;
          if (op_ins_r) begin
            rd_addr_nxt = rd_addr_r - AW'(1);
            wa_nxt      = rd_addr_r + AW'(1);
          end else begin
            rd_addr_nxt = rd_addr_r + AW'(1);
            wa_nxt      = rd_addr_r - AW'(1);
          end
        end
      end
      pidl_pkg::S_PUTVAL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_addr_r;
        ram_wr_data = val_r;
      end
      pidl_pkg::S_RDATA: begin
        res_nxt.read_value = ram_rdata;
      end
      pidl_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != pidl_pkg::S_IDLE);
  assign res_valid = (state_r == pidl_pkg::S_DONE);
  assign res       = res_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidl_pkg::S_IDLE;
      count_r <= '0;
      left_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    wa_r       <= wa_nxt;
    pos_addr_r <= pos_addr_nxt;
    op_ins_r   <= op_ins_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
  end

endmodule

[hdl/positional_insert_delete_list_core.sv]
`timescale 1ns / 1ps

// channel | direction | handshake                 | payload
// in_     | input     | in_valid / in_stall       | pidl_pkg::in_t  cmd, position, new_value
// out_    | output    | out_valid / out_stall     | pidl_pkg::out_t status, element_count, read_value
//
// a delete moves count - position entries and an insert moves count + 1 - position
// entries, one entry per cycle through the single read and single write port of the
// entry memory; an insert then writes its new value in S_PUTVAL.
// a read passes through S_RDATA, a rejected command goes straight to S_DONE.
// one transaction is worked on at a time; the next is taken once the result
// has moved to the output register. reset clears the count but not the entries;
// entries beyond the count are never read. out_stall holds the result in place.

module positional_insert_delete_list_core #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pidl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pidl_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic           ram_rd_en, ram_wr_en;
  logic [AW-1:0]  ram_rd_addr, ram_wr_addr;
  logic [31:0]    ram_rdata, ram_wr_data;
  logic           res_valid, res_take;
  pidl_pkg::out_t res;

  logic           out_valid_r, out_valid_nxt;
  pidl_pkg::out_t out_data_r;

  pidl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rdata   (ram_rdata),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  pidl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  // output register, free when empty or being drained
  assign res_take      = !out_valid_r || !out_stall;
  assign out_valid_nxt = (res_valid && res_take) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/pidl_checker.sv]
`timescale 1ns / 1ps
`include "positional_insert_delete_list_core_defines.svh"

module pidl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input pidl_pkg::out_t out_data
);

  // one transaction in flight: an accepted transaction closes the input
  `PIDL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
                    "second transaction taken while busy")

  // a failed command never returns data
  `PIDL_ASSERT_NOW(a_fail_no_data,
                   !out_valid || (out_data.status == pidl_pkg::STAT_OK) ||
                   (out_data.read_value == '0),
                   "failed command returned data")

  // an empty report only comes from an empty list
  `PIDL_ASSERT_NOW(a_empty_count,
                   !out_valid || (out_data.status != pidl_pkg::STAT_EMPTY) ||
                   (out_data.element_count == '0),
                   "empty status with nonzero count")

  // a stalled result holds
  `PIDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
                    "stalled result changed")

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (.*);

[dv/positional_insert_delete_list_core_tb.sv]
`timescale 1ns / 1ps

module positional_insert_delete_list_core_tb;

  localparam int LIST_DEPTH = pidl_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_LEN = 125;
  localparam int TAIL_CYCLES = LIST_DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;

  // the spare command code, treated by the block as a bad position
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum {GROW, SHRINK, CHURN} mix_t;

  // shadow copy of the list and queue of results still to arrive
  class list_shadow_t;
    logic signed [31:0] slots [LIST_DEPTH];
    int                 fill;
    pidl_pkg::out_t     awaited[$];
    int unsigned        mismatches;
    int unsigned        status_seen [4];
    int unsigned        full_deletes;
    int                 peak;

    function new();
      foreach (slots[k]) slots[k] = '0;
      fill = 0;
      mismatches = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      full_deletes = 0;
      peak = 0;
    endfunction

    // work out the result of an accepted transaction and queue it
    function void note_command(pidl_pkg::in_t item);
      pidl_pkg::out_t want;
      int             pos;
      want.status = pidl_pkg::STAT_BADPOS;
      want.read_value = '0;
      pos = int'(item.position);
      case (item.cmd)
        pidl_pkg::CMD_DELETE: begin
          if (fill == 0) begin
            want.status = pidl_pkg::STAT_EMPTY;
          end else if (pos >= 1 && pos <= fill) begin
            if (fill == LIST_DEPTH) full_deletes++;
            for (int k = pos - 1; k + 1 < fill; k++) slots[k] = slots[k + 1];
            slots[fill - 1] = '0;
            fill--;
            want.status = pidl_pkg::STAT_OK;
          end
        end
        pidl_pkg::CMD_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            want.status = pidl_pkg::STAT_FULL;
          end else if (pos >= 1 && pos <= fill + 1) begin
            for (int k = fill; k > pos - 1; k--) slots[k] = slots[k - 1];
            slots[pos - 1] = item.new_value;
            fill++;
            want.status = pidl_pkg::STAT_OK;
          end
        end
        pidl_pkg::CMD_READ: begin
          if (pos >= 1 && pos <= fill) begin
            want.read_value = slots[pos - 1];
            want.status = pidl_pkg::STAT_OK;
          end
        end
        default: ;
      endcase
      want.element_count = fill[6:0];
      if (fill > peak) peak = fill;
      status_seen[want.status]++;
      awaited.push_back(want);
    endfunction

    // compare a result with the oldest one awaited
    function void check_result(pidl_pkg::out_t got);
      pidl_pkg::out_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d element_count %0d read_value %0d",
               got.status, got.element_count, got.read_value);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.element_count !== want.element_count) begin
        $error("element_count: expected %0d, actual %0d",
               want.element_count, got.element_count);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  pidl_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  pidl_pkg::out_t out_data;
  bit             calm = 1'b0;
  int unsigned    cycles = 0;
  list_shadow_t   sb;

  positional_insert_delete_list_core #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic pidl_pkg::in_t make_cmd(logic [1:0] cmd, logic [6:0] pos,
                                             logic [31:0] val);
    pidl_pkg::in_t item;
    item.cmd = cmd;
    item.position = pos;
    item.new_value = val;
    return item;
  endfunction

  // position mostly in range, edges favoured, some out of range
  function automatic logic [6:0] pick_position(int lo, int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (hi >= lo && roll < 70) return 7'($urandom_range(lo, hi));
    if (hi >= lo && roll < 82) return 7'(roll[0] ? lo : hi);
    if (roll < 87) return 7'd0;
    if (roll < 93) return 7'(hi + 1);
    if (roll < 96) return 7'd127;
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic pidl_pkg::in_t pick_command(mix_t mode);
    pidl_pkg::in_t item;
    int            roll;
    int            len;
    int            ins_odds;
    int            del_odds;
    len = sb.fill;
    roll = $urandom_range(0, 99);
    case (mode)
      GROW:    begin ins_odds = 70; del_odds = 10; end
      SHRINK:  begin ins_odds = 10; del_odds = 70; end
      default: begin ins_odds = 35; del_odds = 35; end
    endcase
    item.new_value = $urandom;
    if (roll < ins_odds) begin
      item.cmd = pidl_pkg::CMD_INSERT;
      item.position = pick_position(1, len + 1);
    end else begin
      if (roll < ins_odds + del_odds) item.cmd = pidl_pkg::CMD_DELETE;
      else if (roll < 96) item.cmd = pidl_pkg::CMD_READ;
      else item.cmd = CMD_UNUSED;
      item.position = pick_position(1, len);
    end
    return item;
  endfunction

  // present one transaction and hold it until taken; returns at a falling edge
  task automatic send_command(input pidl_pkg::in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_command(item);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold off until every awaited result is in
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.awaited.size() != 0);
  endtask

  initial begin
    int idle_odds;
    mix_t mode;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, precedence of checks, extremes of value and position
    send_command(make_cmd(pidl_pkg::CMD_READ,   7'd1,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd1,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd0,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd0,   32'h1234_5678));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd2,   32'h1234_5678));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd1,   32'h7fff_ffff));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd1,   32'h8000_0000));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd3,   32'hffff_ffff));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd2,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_READ,   7'd0,   32'h0));
    for (int p = 1; p <= 5; p++) send_command(make_cmd(pidl_pkg::CMD_READ, p[6:0], 32'h0));
    send_command(make_cmd(pidl_pkg::CMD_READ,   7'd127, 32'hffff_ffff));
    send_command(make_cmd(CMD_UNUSED,           7'd1,   32'h5555_aaaa));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd5,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd127, 32'h0));
    send_command(make_cmd(pidl_pkg::CMD_INSERT, 7'd127, 32'haaaa_5555));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd2,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_DELETE, 7'd3,   32'h0));
    send_command(make_cmd(pidl_pkg::CMD_READ,   7'd1,   32'h0));
    drain_results();

    // random phases: grow toward capacity, shrink, churn
    for (int ph = 0; ph < RANDOM_ITEMS / PHASE_LEN; ph++) begin
      calm = (ph >= RANDOM_ITEMS / PHASE_LEN - 2);
      mode = mix_t'(ph % 3);
      idle_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(3, 12);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          sender_gap($urandom_range(1, 16));
        send_command(pick_command(mode));
      end
      if (ph % 3 == 2) drain_results();
    end

    // wind down
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.awaited.size() != 0) begin
      $error("%0d results never arrived", sb.awaited.size());
      sb.mismatches++;
    end
    $display("run covered %0d ok, %0d empty, %0d full and %0d bad-position transactions",
             sb.status_seen[pidl_pkg::STAT_OK], sb.status_seen[pidl_pkg::STAT_EMPTY],
             sb.status_seen[pidl_pkg::STAT_FULL], sb.status_seen[pidl_pkg::STAT_BADPOS]);
    $display("longest list %0d entries, %0d deletes from a full list",
             sb.peak, sb.full_deletes);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pidl_pkg.sv
hdl/pidl_ram.sv
hdl/pidl_ctrl.sv
hdl/positional_insert_delete_list_core.sv
hdl/pidl_checker.sv
dv/positional_insert_delete_list_core_tb.sv
